// ----- rtl/mrf_pkg.sv -----
`timescale 1ns / 1ps

package mrf_pkg;

  // input item kinds
  localparam logic [1:0] KIND_WRITE_SINGLE = 2'd0;
  localparam logic [1:0] KIND_READ_HOLDING = 2'd1;
  localparam logic [1:0] KIND_MULTI_HEADER = 2'd2;
  localparam logic [1:0] KIND_MULTI_DATA   = 2'd3;

  // modbus function codes
  localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FN_READ_HOLDING = 8'h03;
  localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;

  // reflected crc-16
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned BUF_BYTES = 7;

  // one decoded item handed to the byte serialiser
  typedef struct packed {
    logic                          err;
    logic                          crc_tail;
    logic [2:0]                    n_data;
    logic [BUF_BYTES-1:0][7:0]     bytes;
  } emit_item_t;

endpackage

// ----- rtl/modbus_rtu_request_framer.sv -----
`timescale 1ns / 1ps

// modbus rtu master request framer: each input beat is one request item and
// the output gives the frame bytes one beat at a time in line order, the
// reflected crc-16 (init ffff, poly a001) appended low byte first. write single
// and read holding items give eight bytes, a write-multiple header gives seven,
// and each data word gives two (four on the word that closes the frame). a
// rejected item gives one error beat with a zero byte. an item occupies the
// output for one cycle per byte it makes while out_ready is high; the limit
// is the one-byte-per-cycle crc and output register. the next item is held
// in an input register and is decoded in the cycle its predecessor's last
// byte leaves, so bytes of consecutive items follow without a gap unless
// out_ready stalls. slave_address is written on the cfg beat and must only
// change while the block is idle.

module modbus_rtu_request_framer import mrf_pkg::*; #(
  parameter int MAX_VALUES = 123
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] register_address,
  input  logic [15:0] operand_word,
  input  logic [6:0]  value_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        frame_end,
  output logic        last_in_run,
  output logic        error
);

  // configuration
  logic [7:0] slave_address;

  // input register
  logic        a_valid;
  logic [1:0]  a_kind;
  logic [15:0] a_reg;
  logic [15:0] a_word;
  logic [6:0]  a_count;

  // write-multiple frame tracking
  logic       frame_open;
  logic       frame_open_next;
  logic [6:0] words_remaining;
  logic [6:0] words_remaining_next;
  logic [6:0] words_dec;

  emit_item_t item;
  logic       item_ready;
  logic       take;

  assign cfg_ready = 1'b1;
  assign take      = a_valid && item_ready;
  assign in_ready  = !a_valid || item_ready;
  assign words_dec = words_remaining - 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      slave_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid <= 1'b1;
    end else if (take) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_kind  <= kind;
      a_reg   <= register_address;
      a_word  <= operand_word;
      a_count <= value_count;
    end
  end

  // decode the held item into the bytes it sends; the crc is added downstream
  always_comb begin
    item                 = '0;
    frame_open_next      = frame_open;
    words_remaining_next = words_remaining;
    priority if (a_kind == KIND_MULTI_DATA) begin
      if (!frame_open) begin
        item.err = 1'b1;
      end else begin
        item.bytes[0]        = a_word[15:8];
        item.bytes[1]        = a_word[7:0];
        item.n_data          = 3'd2;
        words_remaining_next = words_dec;
        // last word of the frame closes it with the crc
        if (words_dec == 7'd0) begin
          item.crc_tail   = 1'b1;
          frame_open_next = 1'b0;
        end
      end
    end else if (frame_open) begin
      item.err = 1'b1;
    end else if (a_kind == KIND_MULTI_HEADER) begin
      if (a_count == 7'd0 || a_count > 7'(MAX_VALUES)) begin
        item.err = 1'b1;
      end else begin
        item.bytes[0]        = slave_address;
        item.bytes[1]        = FN_WRITE_MULTI;
        item.bytes[2]        = a_reg[15:8];
        item.bytes[3]        = a_reg[7:0];
        item.bytes[4]        = a_word[15:8];
        item.bytes[5]        = a_word[7:0];
        item.bytes[6]        = {a_count, 1'b0};
        item.n_data          = 3'd7;
        frame_open_next      = 1'b1;
        words_remaining_next = a_count;
      end
    end else begin
      // the crc is always at init here: no frame is open
      item.bytes[0] = slave_address;
      item.bytes[1] = (a_kind == KIND_WRITE_SINGLE) ? FN_WRITE_SINGLE : FN_READ_HOLDING;
      item.bytes[2] = a_reg[15:8];
      item.bytes[3] = a_reg[7:0];
      item.bytes[4] = a_word[15:8];
      item.bytes[5] = a_word[7:0];
      item.n_data   = 3'd6;
      item.crc_tail = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      words_remaining <= 7'd0;
    end else if (take) begin
      frame_open      <= frame_open_next;
      words_remaining <= words_remaining_next;
    end
  end

  // byte serialiser with running crc and output register
  mrf_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (a_valid),
    .load_item   (item),
    .load_ready  (item_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_byte  (frame_byte),
    .frame_end   (frame_end),
    .last_in_run (last_in_run),
    .error       (error)
  );

endmodule

// ----- rtl/mrf_emitter.sv -----
`timescale 1ns / 1ps

module mrf_emitter import mrf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load_valid,
  input  emit_item_t load_item,
  output logic       load_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_byte,
  output logic       frame_end,
  output logic       last_in_run,
  output logic       error
);

  function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic                      e_valid;
  logic                      e_err;
  logic [2:0]                data_left;
  logic [1:0]                crc_left;
  logic [BUF_BYTES-1:0][7:0] sh;
  logic [15:0]               crc;

  logic       out_free;
  logic       advance;
  logic       e_last;
  logic       load;
  logic [7:0] byte_next;
  logic       end_next;
  logic       last_next;
  logic       err_next;

  assign out_free   = !out_valid || out_ready;
  assign advance    = e_valid && out_free;
  assign e_last     = e_err || (data_left == 3'd1 && crc_left == 2'd0)
                      || (data_left == 3'd0 && crc_left == 2'd1);
  assign load_ready = !e_valid || (advance && e_last);
  assign load       = load_valid && load_ready;

  always_comb begin
    priority if (e_err) begin
      byte_next = 8'h00;
      end_next  = 1'b0;
      last_next = 1'b1;
      err_next  = 1'b1;
    end else if (data_left != 3'd0) begin
      byte_next = sh[0];
      end_next  = 1'b0;
      last_next = e_last;
      err_next  = 1'b0;
    end else if (crc_left == 2'd2) begin
      byte_next = crc[7:0];
      end_next  = 1'b0;
      last_next = 1'b0;
      err_next  = 1'b0;
    end else begin
      byte_next = crc[15:8];
      end_next  = 1'b1;
      last_next = 1'b1;
      err_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      e_err     <= 1'b0;
      data_left <= 3'd0;
      crc_left  <= 2'd0;
      crc       <= CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // crc follows the data bytes as they leave, back to init after the high byte
      if (advance && !e_err) begin
        if (data_left != 3'd0) begin
          crc <= crc16_byte(crc, sh[0]);
        end else if (crc_left == 2'd1) begin
          crc <= CRC_INIT;
        end
      end

      if (load) begin
        e_valid   <= 1'b1;
        e_err     <= load_item.err;
        data_left <= load_item.n_data;
        crc_left  <= load_item.crc_tail ? 2'd2 : 2'd0;
      end else if (advance && e_last) begin
        e_valid <= 1'b0;
      end else if (advance) begin
        if (data_left != 3'd0) begin
          data_left <= data_left - 3'd1;
        end else begin
          crc_left <= crc_left - 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh <= load_item.bytes;
    end else if (advance && data_left != 3'd0) begin
      sh <= {8'h00, sh[BUF_BYTES-1:1]};
    end
    if (advance) begin
      frame_byte  <= byte_next;
      frame_end   <= end_next;
      last_in_run <= last_next;
      error       <= err_next;
    end
  end

endmodule

// ----- rtl/mrf_checker.sv -----
`timescale 1ns / 1ps

module mrf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  frame_byte,
  input logic        frame_end,
  input logic        last_in_run,
  input logic        error
);

  // the closing crc byte always ends the item's run and is never an error
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> last_in_run && !error)
    else $error("frame end without last of run");

  // error beat layout
  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> frame_byte == 8'h00 && last_in_run && !frame_end)
    else $error("malformed error beat");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(frame_end)
      && $stable(last_in_run) && $stable(error))
    else $error("output beat changed while stalled");

  // nothing leaves straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind modbus_rtu_request_framer mrf_checker u_mrf_checker (.*);
